// ===== src/smat_pkg.sv =====
// Shared types and constants for the small matrix add/multiply/transpose block.
package smat_pkg;

  localparam int DIM_DEF = 3;   // default matrix dimension
  localparam int DIM_MAX = 8;   // largest supported dimension
  localparam int IDX_W   = 3;   // row/column index width
  localparam int ELEM_W  = 16;  // matrix element width
  localparam int PROD_W  = 32;  // one element product
  localparam int SUM_W   = 17;  // A + B
  localparam int ACC_W   = 35;  // dot product of DIM_MAX terms

  typedef enum logic {
    ST_LOAD,
    ST_RUN
  } smat_state_t;

  // Tag that travels with one read pair down the multiply-accumulate pipe.
  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] k;
    logic             first;    // first term of a dot product
    logic             lastk;    // last term of a dot product
    logic             run_end;  // last term of the last element of the run
  } smat_tag_t;

endpackage

// ===== src/smat_mac.sv =====
// Multiply-accumulate pipe and result register for the matrix block.
module smat_mac (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   s1_vld,
  input  smat_pkg::smat_tag_t                    s1_tag,
  input  logic signed [smat_pkg::ELEM_W-1:0]     a_rd,
  input  logic signed [smat_pkg::ELEM_W-1:0]     b_rd,
  input  logic signed [smat_pkg::ELEM_W-1:0]     at_rd,
  output logic                                   out_valid,
  output logic        [smat_pkg::IDX_W-1:0]      out_row,
  output logic        [smat_pkg::IDX_W-1:0]      out_col,
  output logic signed [smat_pkg::SUM_W-1:0]      out_sum,
  output logic signed [smat_pkg::ACC_W-1:0]      out_product,
  output logic signed [smat_pkg::ELEM_W-1:0]     out_transposed,
  output logic                                   out_last
);
  import smat_pkg::*;

  // stage 2: product register plus captured element values
  logic                     s2_vld_r;
  smat_tag_t                s2_tag_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ELEM_W-1:0] cap_a_r;
  logic signed [ELEM_W-1:0] cap_b_r;
  logic signed [ELEM_W-1:0] cap_t_r;

  // stage 3: accumulator and result registers
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic signed [SUM_W-1:0]  sum_nxt;
  logic                     out_valid_r;
  logic [IDX_W-1:0]         out_row_r;
  logic [IDX_W-1:0]         out_col_r;
  logic signed [SUM_W-1:0]  out_sum_r;
  logic signed [ACC_W-1:0]  out_prod_r;
  logic signed [ELEM_W-1:0] out_t_r;
  logic                     out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld) begin
      prod_r   <= a_rd * b_rd;
      s2_tag_r <= s1_tag;
      cap_t_r  <= at_rd;
      // A[r][c] shows up on the A stream when k == c, B[r][c] on the B stream when k == r
      if (s1_tag.k == s1_tag.col) begin
        cap_a_r <= a_rd;
      end
      if (s1_tag.k == s1_tag.row) begin
        cap_b_r <= b_rd;
      end
    end
  end

  always_comb begin
    acc_nxt = (s2_tag_r.first ? '0 : acc_r) + {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
    sum_nxt = {cap_a_r[ELEM_W-1], cap_a_r} + {cap_b_r[ELEM_W-1], cap_b_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s2_vld_r && s2_tag_r.lastk;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_vld_r) begin
      acc_r <= acc_nxt;
      if (s2_tag_r.lastk) begin
        out_row_r  <= s2_tag_r.row;
        out_col_r  <= s2_tag_r.col;
        out_sum_r  <= sum_nxt;
        out_prod_r <= acc_nxt;
        out_t_r    <= cap_t_r;
        out_last_r <= s2_tag_r.run_end;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_row        = out_row_r;
  assign out_col        = out_col_r;
  assign out_sum        = out_sum_r;
  assign out_product    = out_prod_r;
  assign out_transposed = out_t_r;
  assign out_last       = out_last_r & out_valid_r;

endmodule

// ===== src/small_matrix_add_mul_transpose.sv =====
// Top level: loads two DIMxDIM matrices and streams sum, product and transpose.
//
//  channel | ports                                         | handshake
//  --------+-----------------------------------------------+--------------------------
//  input   | in_a_value, in_b_value                        | start & !busy
//  result  | out_row, out_col, out_sum, out_product,       | out_valid, one cycle,
//          | out_transposed, out_last                      | no back-pressure
//
// Loading takes one request per cycle while busy is low; DIM*DIM requests fill both stores.
// The request that fills them starts a run of DIM*DIM*DIM A/B memory read pairs
// (one per multiply-accumulate term); busy is high for that run.
// Each result is registered after its last term passes the read-data, product and
// accumulator registers, one result per element; the last one comes after busy drops.
// Reset (rst_n low, synchronous) clears the load counter and sequencer; store
// contents are not cleared. Results cannot be stalled; none are buffered.
module small_matrix_add_mul_transpose #(
  parameter int DIM = smat_pkg::DIM_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [smat_pkg::ELEM_W-1:0]     in_a_value,
  input  logic signed [smat_pkg::ELEM_W-1:0]     in_b_value,
  output logic                                   out_valid,
  output logic        [smat_pkg::IDX_W-1:0]      out_row,
  output logic        [smat_pkg::IDX_W-1:0]      out_col,
  output logic signed [smat_pkg::SUM_W-1:0]      out_sum,
  output logic signed [smat_pkg::ACC_W-1:0]      out_product,
  output logic signed [smat_pkg::ELEM_W-1:0]     out_transposed,
  output logic                                   out_last
);
  import smat_pkg::*;

  localparam int CELLS = DIM * DIM;
  localparam int AW    = $clog2(CELLS);
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(DIM - 1);
  localparam logic [AW-1:0]    CELL_LAST = AW'(CELLS - 1);

  // Sequencer
  smat_state_t      state_r;
  smat_state_t      state_nxt;
  logic             in_acc;
  logic             run_issue;
  logic [AW-1:0]    load_cnt_r;
  logic [AW-1:0]    load_cnt_nxt;
  logic [IDX_W-1:0] iss_r_r, iss_r_nxt;
  logic [IDX_W-1:0] iss_c_r, iss_c_nxt;
  logic [IDX_W-1:0] iss_k_r, iss_k_nxt;
  logic             k_wrap;
  logic             c_wrap;
  logic             run_done;

  // Memory addresses and registered read data
  logic [AW-1:0]            addr_a;
  logic [AW-1:0]            addr_b;
  logic [AW-1:0]            addr_t;
  logic signed [ELEM_W-1:0] mem_a [CELLS];
  logic signed [ELEM_W-1:0] mem_b [CELLS];
  logic signed [ELEM_W-1:0] a_rd_r;
  logic signed [ELEM_W-1:0] b_rd_r;
  logic signed [ELEM_W-1:0] at_rd_r;
  logic                     s1_vld_r;
  smat_tag_t                s1_tag_r;
  smat_tag_t                iss_tag;

  assign in_acc   = start && !busy;
  assign k_wrap   = (iss_k_r == IDX_LAST);
  assign c_wrap   = (iss_c_r == IDX_LAST);
  assign run_done = k_wrap && c_wrap && (iss_r_r == IDX_LAST);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (in_acc && (load_cnt_r == CELL_LAST)) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (run_done) begin
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // state outputs
  always_comb begin
    busy      = 1'b1;
    run_issue = 1'b0;
    case (state_r)
      ST_LOAD: begin
        busy = 1'b0;
      end
      ST_RUN: begin
        run_issue = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // load counter and k/c/r issue counters (k fastest)
  always_comb begin
    load_cnt_nxt = load_cnt_r;
    if (in_acc) begin
      load_cnt_nxt = (load_cnt_r == CELL_LAST) ? '0 : load_cnt_r + 1'b1;
    end
    iss_k_nxt = iss_k_r;
    iss_c_nxt = iss_c_r;
    iss_r_nxt = iss_r_r;
    if (run_issue) begin
      iss_k_nxt = k_wrap ? '0 : iss_k_r + 1'b1;
      if (k_wrap) begin
        iss_c_nxt = c_wrap ? '0 : iss_c_r + 1'b1;
        if (c_wrap) begin
          iss_r_nxt = (iss_r_r == IDX_LAST) ? '0 : iss_r_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_LOAD;
      load_cnt_r <= '0;
      iss_r_r    <= '0;
      iss_c_r    <= '0;
      iss_k_r    <= '0;
      s1_vld_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      load_cnt_r <= load_cnt_nxt;
      iss_r_r    <= iss_r_nxt;
      iss_c_r    <= iss_c_nxt;
      iss_k_r    <= iss_k_nxt;
      s1_vld_r   <= run_issue;
    end
  end

  // A[r][k], B[k][c] for the dot product; A[c][r] for the transpose
  assign addr_a = AW'(32'(iss_r_r) * DIM + 32'(iss_k_r));
  assign addr_b = AW'(32'(iss_k_r) * DIM + 32'(iss_c_r));
  assign addr_t = AW'(32'(iss_c_r) * DIM + 32'(iss_r_r));

  always_comb begin
    iss_tag.row     = iss_r_r;
    iss_tag.col     = iss_c_r;
    iss_tag.k       = iss_k_r;
    iss_tag.first   = (iss_k_r == '0);
    iss_tag.lastk   = k_wrap;
    iss_tag.run_end = run_done;
  end

  // Store writes: one pair per accepted request
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mem_a[load_cnt_r] <= in_a_value;
      mem_b[load_cnt_r] <= in_b_value;
    end
  end

  // Store reads: A has two read ports, B one; data registered
  always_ff @(posedge clk) begin
    a_rd_r   <= mem_a[addr_a];
    at_rd_r  <= mem_a[addr_t];
    b_rd_r   <= mem_b[addr_b];
    s1_tag_r <= iss_tag;
  end

  smat_mac u_mac (
    .clk            (clk),
    .rst_n          (rst_n),
    .s1_vld         (s1_vld_r),
    .s1_tag         (s1_tag_r),
    .a_rd           (a_rd_r),
    .b_rd           (b_rd_r),
    .at_rd          (at_rd_r),
    .out_valid      (out_valid),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_sum        (out_sum),
    .out_product    (out_product),
    .out_transposed (out_transposed),
    .out_last       (out_last)
  );

  // A run always starts from an empty load counter and from the first term
  a_run_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD) && (state_nxt == ST_RUN) |=>
      (load_cnt_r == '0) && (iss_r_r == '0) && (iss_c_r == '0) && (iss_k_r == '0))
    else $error("run started with stale counters");

  // Issue counters only move during a run
  a_iss_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD) |=> $stable(iss_k_r) && $stable(iss_c_r) && $stable(iss_r_r))
    else $error("issue counters moved while loading");

  // Last result of a run is never followed directly by another result
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid)
    else $error("result right after last of run");

  // Last term of the run leaves the pipe as a marked result
  a_last_lat: assert property (@(posedge clk) disable iff (!rst_n)
    run_issue && run_done |-> ##3 (out_valid && out_last))
    else $error("last result missing");

  // Load counter stays inside the store
  a_load_rng: assert property (@(posedge clk) disable iff (!rst_n)
    load_cnt_r <= CELL_LAST)
    else $error("load counter out of range");

endmodule

// ===== sim/smat_result_checker.sv =====
// Result checker for the matrix block: tracks loaded cells and compares every result element.
module smat_result_checker #(
  parameter int DIM = smat_pkg::DIM_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic                               busy,
  input  logic signed [smat_pkg::ELEM_W-1:0] in_a_value,
  input  logic signed [smat_pkg::ELEM_W-1:0] in_b_value,
  input  logic                               out_valid,
  input  logic        [smat_pkg::IDX_W-1:0]  out_row,
  input  logic        [smat_pkg::IDX_W-1:0]  out_col,
  input  logic signed [smat_pkg::SUM_W-1:0]  out_sum,
  input  logic signed [smat_pkg::ACC_W-1:0]  out_product,
  input  logic signed [smat_pkg::ELEM_W-1:0] out_transposed,
  input  logic                               out_last,
  output int                                 fail_count,
  output int                                 pending,
  output int                                 elems_checked
);
  import smat_pkg::*;

  localparam int CELLS = DIM * DIM;

  typedef struct {
    logic        [IDX_W-1:0]  row;
    logic        [IDX_W-1:0]  col;
    logic signed [SUM_W-1:0]  sum;
    logic signed [ACC_W-1:0]  product;
    logic signed [ELEM_W-1:0] transposed;
    logic                     last;
  } elem_result_t;

  elem_result_t             expected_elems[$];
  elem_result_t             head;
  logic signed [ELEM_W-1:0] a_cells[CELLS];
  logic signed [ELEM_W-1:0] b_cells[CELLS];
  int unsigned              cells_loaded;

  // Full set loaded: queue all DIM*DIM elements in row-major order.
  task automatic queue_matrix_results();
    elem_result_t e;
    longint       dot;
    int           r;
    int           c;
    int           k;
    for (r = 0; r < DIM; r++) begin
      for (c = 0; c < DIM; c++) begin
        dot = 0;
        for (k = 0; k < DIM; k++)
          dot += longint'(a_cells[r*DIM+k]) * longint'(b_cells[k*DIM+c]);
        e.row        = IDX_W'(r);
        e.col        = IDX_W'(c);
        e.sum        = SUM_W'(longint'(a_cells[r*DIM+c]) + longint'(b_cells[r*DIM+c]));
        e.product    = ACC_W'(dot);
        e.transposed = a_cells[c*DIM+r];
        e.last       = (r == DIM - 1) && (c == DIM - 1);
        expected_elems.push_back(e);
      end
    end
  endtask

  task automatic check_field(string name, logic signed [63:0] exp_v, logic signed [63:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      cells_loaded = 0;
    end else begin
      if (start && !busy) begin
        if (cells_loaded >= CELLS) cells_loaded = 0;
        a_cells[cells_loaded] = in_a_value;
        b_cells[cells_loaded] = in_b_value;
        cells_loaded++;
        if (cells_loaded == CELLS) begin
          queue_matrix_results();
          cells_loaded = 0;
        end
      end
      if (out_valid) begin
        if (expected_elems.size() == 0) begin
          $error("unexpected result at row %0d col %0d, nothing pending", out_row, out_col);
          fail_count++;
        end else begin
          head = expected_elems.pop_front();
          check_field("out_row", head.row, out_row);
          check_field("out_col", head.col, out_col);
          check_field("out_sum", head.sum, out_sum);
          check_field("out_product", head.product, out_product);
          check_field("out_transposed", head.transposed, out_transposed);
          check_field("out_last", head.last, out_last);
          elems_checked++;
        end
      end
    end
    pending <= expected_elems.size();
  end

endmodule

// ===== sim/small_matrix_add_mul_transpose_tb.sv =====
// Testbench top: drives matrix load requests into the block and reports the verdict.
module small_matrix_add_mul_transpose_tb;
  import smat_pkg::*;

  localparam int DIM         = DIM_DEF;
  localparam int CELLS       = DIM * DIM;
  // Tail wait: long enough for a full run and its pipeline, twice over.
  localparam int TAIL_CYCLES = 2 * DIM * DIM * DIM + 8;
  // ~460 requests, each with a random idle gap at heavy idling, plus one run per
  // matrix; the limit is many times the slowest expected run.
  localparam int CYCLE_LIMIT = 200_000;
  localparam int PHASE_SETS  = 16;  // random matrix pairs per pacing phase

  typedef enum int {
    VAL_FULL,
    VAL_EDGE,
    VAL_SMALL
  } val_style_t;

  logic                     clk        = 1'b0;
  logic                     rst_n      = 1'b0;
  logic                     start      = 1'b0;
  logic signed [ELEM_W-1:0] in_a_value = '0;
  logic signed [ELEM_W-1:0] in_b_value = '0;

  logic                     busy;
  logic                     out_valid;
  logic        [IDX_W-1:0]  out_row;
  logic        [IDX_W-1:0]  out_col;
  logic signed [SUM_W-1:0]  out_sum;
  logic signed [ACC_W-1:0]  out_product;
  logic signed [ELEM_W-1:0] out_transposed;
  logic                     out_last;

  int fail_count;
  int pending;
  int elems_checked;
  int requests_sent = 0;
  int cycle_count   = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  small_matrix_add_mul_transpose #(.DIM(DIM)) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_a_value     (in_a_value),
    .in_b_value     (in_b_value),
    .out_valid      (out_valid),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_sum        (out_sum),
    .out_product    (out_product),
    .out_transposed (out_transposed),
    .out_last       (out_last)
  );

  // Checker sits beside the block, sees both channels, owns all prediction.
  smat_result_checker #(.DIM(DIM)) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_a_value     (in_a_value),
    .in_b_value     (in_b_value),
    .out_valid      (out_valid),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_sum        (out_sum),
    .out_product    (out_product),
    .out_transposed (out_transposed),
    .out_last       (out_last),
    .fail_count     (fail_count),
    .pending        (pending),
    .elems_checked  (elems_checked)
  );

  // Watchdog: a hang or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still pending", cycle_count, pending);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Element values: full range, corner values, or small magnitudes.
  function automatic logic signed [ELEM_W-1:0] pick_elem(val_style_t style);
    logic signed [ELEM_W-1:0] v;
    case (style)
      VAL_EDGE: begin
        case ($urandom_range(4))
          0:       v = 16'sh8000;
          1:       v = 16'sh7fff;
          2:       v = '0;
          3:       v = -16'sd1;
          default: v = 16'sd1;
        endcase
      end
      VAL_SMALL: v = ELEM_W'($signed($urandom_range(20)) - 10);
      default:   v = ELEM_W'($urandom);
    endcase
    return v;
  endfunction

  // One request: hold start until the block takes it (start & !busy at an edge).
  // start is left high so back-to-back requests never toggle it within a step.
  task automatic send_pair(logic signed [ELEM_W-1:0] a, logic signed [ELEM_W-1:0] b);
    start      <= 1'b1;
    in_a_value <= a;
    in_b_value <= b;
    do @(posedge clk); while (busy);
    requests_sent++;
  endtask

  // Idle for a geometric number of cycles; pct is the per-cycle idle chance.
  task automatic idle_gap(int unsigned pct);
    while ($urandom_range(99) < pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Sender holds off until every queued result element has been seen.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // One random matrix pair. Most sets mix full-range values with corner and
  // small values; a few are all corners or all small to hit sign/carry extremes.
  task automatic send_random_set(int unsigned pct);
    int unsigned kind;
    int unsigned pick;
    int          i;
    val_style_t  style;
    kind = $urandom_range(9);
    for (i = 0; i < CELLS; i++) begin
      if (kind == 0) begin
        style = VAL_EDGE;
      end else if (kind == 1) begin
        style = VAL_SMALL;
      end else begin
        pick  = $urandom_range(9);
        style = (pick < 7) ? VAL_FULL : (pick < 9) ? VAL_EDGE : VAL_SMALL;
      end
      send_pair(pick_elem(style), pick_elem(style));
      idle_gap(pct);
    end
  endtask

  int unsigned phase_pct[3] = '{0, 85, 33};

  initial begin
    int i;
    int ph;
    int m;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: most negative times most negative gives the largest product
    // and the lowest sum.
    for (i = 0; i < CELLS; i++) send_pair(16'sh8000, 16'sh8000);
    // Max positive A against most negative B: the most negative product.
    for (i = 0; i < CELLS; i++) send_pair(16'sh7fff, 16'sh8000);
    // Distinct alternating-sign A against a diagonal of max positive B, so a
    // swapped row/column or a wrong transpose shows up at once.
    for (i = 0; i < CELLS; i++)
      send_pair(ELEM_W'((i % 2 == 1) ? -(i + 1) * 3001 : (i + 1) * 3001),
                (i % (DIM + 1) == 0) ? 16'sh7fff : 16'sh0000);
    drain();

    // Random part in three pacing phases: back-to-back, sparse, moderate.
    // Inside the idling phases some sets go back-to-back for a burst.
    for (ph = 0; ph < 3; ph++) begin
      for (m = 0; m < PHASE_SETS; m++)
        send_random_set(($urandom_range(4) == 0) ? 0 : phase_pct[ph]);
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Loaded %0d matrix pairs over %0d requests; checked %0d result elements",
             requests_sent / CELLS, requests_sent, elems_checked);
    $display("Pacing covered back-to-back, 85%% and 33%% sender idling, plus full drains");
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
